// File: src/spectrum_smooth_peak_hold_defines.svh
// assertion macros for the spectrum smoothing block
`ifndef SPECTRUM_SMOOTH_PEAK_HOLD_DEFINES_SVH
`define SPECTRUM_SMOOTH_PEAK_HOLD_DEFINES_SVH
// implication checked at every clock edge outside reset
`define SSPH_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition that must never hold outside reset
`define SSPH_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

// File: src/ssph_pkg.sv
// package with constants, tables and helper functions for spectrum smoothing
`default_nettype none
package ssph_pkg;
  localparam int NumBins = 2048;
  localparam int BinW = 11;
  localparam int Taps = 9;
  localparam logic signed [15:0] FloorDb = -16'sd25600;
  localparam logic [1:0] ModeOff = 2'd0;
  localparam logic [1:0] ModeLight = 2'd1;
  localparam logic [1:0] ModeMedium = 2'd2;
  localparam logic [1:0] ModeHeavy = 2'd3;
  localparam logic CfgMode = 1'b0;
  localparam logic CfgRate = 1'b1;
  // ceil(2^35 / 1000), exact quotient for numerators below 2^25
  localparam logic [25:0] Recip1000 = 26'd34359739;
  localparam int Recip1000Shift = 35;
  localparam int RecipTotalShift = 30;

  function automatic logic [15:0] coef_full(input logic [1:0] m);
    case (m)
      ModeLight: coef_full = 16'd45875;
      ModeMedium: coef_full = 16'd55706;
      ModeHeavy: coef_full = 16'd60948;
      default: coef_full = 16'd0;
    endcase
  endfunction

  function automatic logic [15:0] coef_attack(input logic [1:0] m);
    case (m)
      ModeLight: coef_attack = 16'd22938;
      ModeMedium: coef_attack = 16'd27853;
      ModeHeavy: coef_attack = 16'd30474;
      default: coef_attack = 16'd0;
    endcase
  endfunction

  function automatic logic [2:0] mode_width(input logic [1:0] m);
    case (m)
      ModeLight: mode_width = 3'd1;
      ModeMedium: mode_width = 3'd2;
      ModeHeavy: mode_width = 3'd4;
      default: mode_width = 3'd0;
    endcase
  endfunction

  // ceil(2^29 / t), divides by 2*t after a shift of 30
  function automatic logic [29:0] recip_total(input logic [4:0] t);
    case (t)
      5'd1: recip_total = 30'd536870912;
      5'd2: recip_total = 30'd268435456;
      5'd3: recip_total = 30'd178956971;
      5'd4: recip_total = 30'd134217728;
      5'd5: recip_total = 30'd107374183;
      5'd6: recip_total = 30'd89478486;
      5'd7: recip_total = 30'd76695845;
      5'd8: recip_total = 30'd67108864;
      5'd9: recip_total = 30'd59652324;
      5'd10: recip_total = 30'd53687092;
      5'd11: recip_total = 30'd48806447;
      5'd12: recip_total = 30'd44739243;
      5'd13: recip_total = 30'd41297763;
      5'd14: recip_total = 30'd38347923;
      5'd15: recip_total = 30'd35791395;
      5'd16: recip_total = 30'd33554432;
      5'd17: recip_total = 30'd31580642;
      5'd18: recip_total = 30'd29826162;
      5'd19: recip_total = 30'd28256364;
      5'd20: recip_total = 30'd26843546;
      5'd21: recip_total = 30'd25565282;
      5'd22: recip_total = 30'd24403224;
      5'd23: recip_total = 30'd23342214;
      5'd24: recip_total = 30'd22369622;
      5'd25: recip_total = 30'd21474837;
      default: recip_total = 30'd0;
    endcase
  endfunction
endpackage
`default_nettype wire

// File: src/spectrum_smooth_peak_hold.sv
// spectrum attack/release smoothing with triangular window and peak hold
// channel | direction | fields
// in_     | input     | magnitude_db, elapsed_ms, frame_end
// out_    | output    | bin_index, smoothed_db, peak_db, last
// cfg_    | input     | smoothing_mode (0), peak_decay_rate (1)
// an item without a result steps through accept, store read (frame decay
// reciprocal multiply at a first bin), blend product and blend sum. each
// result adds a peak read with window sum, then window reciprocal and transfer;
// frame end flushes up to 5 results. after reset a clearing pass over all 2048
// bins writes -100 dB to both stores; no item is taken meanwhile. out_stall
// holds the result register; the input stalls until the previous item is done.
`default_nettype none
module spectrum_smooth_peak_hold (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_magnitude_db,
  input  wire logic [15:0]        in_elapsed_ms,
  input  wire logic               in_frame_end,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [10:0]             out_bin_index,
  output logic signed [15:0]      out_smoothed_db,
  output logic signed [15:0]      out_peak_db,
  output logic                    out_last,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_wdata
);
  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle = 3'd1;
  localparam logic [2:0] StDiv = 3'd2;
  localparam logic [2:0] StRead = 3'd3;
  localparam logic [2:0] StMul = 3'd4;
  localparam logic [2:0] StSum = 3'd5;
  localparam logic [2:0] StEmit = 3'd6;
  localparam logic [2:0] StPkRd = 3'd7;

  logic signed [15:0] smem [ssph_pkg::NumBins];
  logic signed [15:0] pmem [ssph_pkg::NumBins];

  logic [2:0] st_r;
  logic [10:0] clr_r;
  logic [1:0] mode_r;
  logic [15:0] rate_r;
  logic [1:0] cur_mode_r;
  logic [2:0] cur_w_r;
  logic [15:0] decay_r;
  logic time_seen_r;
  logic [10:0] cnt_r;
  logic signed [15:0] taps_r [ssph_pkg::Taps];
  logic signed [15:0] x_r;
  logic end_r;
  logic [10:0] c_r;
  logic signed [33:0] prodA_r, prodB_r;
  logic [2:0] d_r;
  logic signed [15:0] peak_hold_r;
  logic [24:0] div_num_r;
  logic [10:0] rd_addr;
  logic signed [15:0] srd_r, prd_r;

  // read port
  always_ff @(posedge clk) begin
    srd_r <= smem[rd_addr];
    prd_r <= pmem[rd_addr];
  end

  logic s_we, p_we;
  logic [10:0] s_wa, p_wa;
  logic signed [15:0] s_wd, p_wd;
  always_ff @(posedge clk) begin
    if (s_we) smem[s_wa] <= s_wd;
    if (p_we) pmem[p_wa] <= p_wd;
  end

  // window sum for offset d
  logic [22:0] win_num;
  logic [4:0] win_total;
  always_comb begin
    logic signed [23:0] sum;
    logic [4:0] total;
    logic [3:0] k;
    logic [2:0] aj;
    sum = '0;
    total = '0;
    for (int j = -4; j <= 4; j++) begin
      aj = (j < 0) ? 3'(-j) : 3'(j);
      k = 4'(int'(d_r) - j);
      if (aj <= cur_w_r && int'(d_r) - j >= 0 && int'(d_r) - j < ssph_pkg::Taps
          && 11'(int'(d_r) - j) <= c_r) begin
        sum = sum + 24'(signed'({1'b0, 4'(cur_w_r + 3'd1 - aj)})) * 24'(taps_r[k]);
        total = total + 5'(cur_w_r + 3'd1 - aj);
      end
    end
    win_total = total;
    win_num = 23'(2 * (32'(sum) + 32'(total) * 65536) + 32'(total));
  end

  logic [22:0] win_num_r;
  logic [4:0] win_total_r;
  always_ff @(posedge clk) begin
    win_num_r <= win_num;
    win_total_r <= win_total;
  end

  // window result through the reciprocal of twice the weight total
  logic signed [15:0] win_res;
  logic [10:0] emit_e;
  always_comb begin
    logic [52:0] prod;
    logic [16:0] q;
    prod = 53'(win_num_r) * 53'(ssph_pkg::recip_total(win_total_r));
    q = 17'(prod >> ssph_pkg::RecipTotalShift);
    if (win_total_r == '0) begin
      win_res = taps_r[{1'b0, d_r}];
    end else begin
      win_res = 16'(q - 17'h10000);
    end
  end
  assign emit_e = c_r - 11'(d_r);

  logic accept;
  assign accept = in_valid && !in_stall;
  assign in_stall = (st_r != StIdle);
  logic out_free;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    rd_addr = (st_r == StClear) ? clr_r : cnt_r;
    if (st_r == StPkRd || st_r == StEmit) rd_addr = emit_e;
    s_we = 1'b0; p_we = 1'b0;
    s_wa = clr_r; p_wa = clr_r;
    s_wd = ssph_pkg::FloorDb; p_wd = ssph_pkg::FloorDb;
    if (st_r == StClear) begin
      s_we = 1'b1; p_we = 1'b1;
    end else if (st_r == StSum) begin
      p_we = 1'b1; p_wa = c_r; p_wd = peak_hold_r;
    end else if (st_r == StEmit && out_free) begin
      s_we = 1'b1; s_wa = emit_e; s_wd = win_res;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [15:0] t;
    logic signed [34:0] bl;
    logic signed [16:0] p;
    logic [50:0] dq;
    if (!rst_n) begin
      st_r <= StClear;
      clr_r <= '0;
      mode_r <= ssph_pkg::ModeMedium;
      rate_r <= 16'd3072;
      cur_mode_r <= '0;
      cur_w_r <= '0;
      decay_r <= '0;
      time_seen_r <= 1'b0;
      cnt_r <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < ssph_pkg::Taps; i++) taps_r[i] <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == ssph_pkg::CfgMode) mode_r <= cfg_wdata[1:0];
        else rate_r <= cfg_wdata;
      end
      if (out_valid && !out_stall && st_r != StEmit) out_valid <= 1'b0;
      case (st_r)
        StClear: begin
          clr_r <= clr_r + 11'd1;
          if (clr_r == 11'(ssph_pkg::NumBins - 1)) st_r <= StIdle;
        end
        StIdle: begin
          if (accept) begin
            x_r <= in_magnitude_db;
            c_r <= cnt_r;
            end_r <= in_frame_end || (cnt_r == 11'(ssph_pkg::NumBins - 1));
            if (cnt_r == '0) begin
              cur_mode_r <= mode_r;
              cur_w_r <= ssph_pkg::mode_width(mode_r);
              div_num_r <= 25'(((in_elapsed_ms > 16'd500) ? 32'd500 :
                32'(in_elapsed_ms)) * 32'(rate_r) + 32'd500);
              if (!time_seen_r) begin
                decay_r <= '0;
                st_r <= StRead;
              end else begin
                st_r <= StDiv;
              end
              time_seen_r <= 1'b1;
            end else begin
              st_r <= StRead;
            end
          end
        end
        StDiv: begin
          // divide by 1000 through a reciprocal multiply
          dq = 51'(div_num_r) * 51'(ssph_pkg::Recip1000);
          decay_r <= 16'(dq >> ssph_pkg::Recip1000Shift);
          st_r <= StMul;
        end
        StRead: st_r <= StMul;
        StMul: begin
          if (x_r > srd_r) begin
            prodA_r <= 34'(signed'({1'b0, ssph_pkg::coef_attack(cur_mode_r)})) * 34'(srd_r);
            prodB_r <= 34'(65536 - int'(ssph_pkg::coef_attack(cur_mode_r))) * 34'(x_r);
          end else begin
            prodA_r <= 34'(signed'({1'b0, ssph_pkg::coef_full(cur_mode_r)})) * 34'(srd_r);
            prodB_r <= 34'(65536 - int'(ssph_pkg::coef_full(cur_mode_r))) * 34'(x_r);
          end
          st_r <= StSum;
          p = 17'(prd_r) - 17'(signed'({1'b0, decay_r}));
          if (p < 17'(ssph_pkg::FloorDb)) p = 17'(ssph_pkg::FloorDb);
          if (17'(x_r) > p) p = 17'(x_r);
          peak_hold_r <= 16'(p);
        end
        StSum: begin
          bl = 35'(prodA_r) + 35'(prodB_r) + 35'sd32768;
          t = (cur_mode_r == ssph_pkg::ModeOff) ? x_r : 16'(bl >>> 16);
          for (int i = ssph_pkg::Taps - 1; i > 0; i--) taps_r[i] <= taps_r[i - 1];
          taps_r[0] <= t;
          if (end_r) begin
            d_r <= (11'(cur_w_r) < c_r) ? cur_w_r : 3'(c_r);
            st_r <= StPkRd;
          end else if (c_r >= 11'(cur_w_r)) begin
            d_r <= cur_w_r;
            st_r <= StPkRd;
          end else begin
            cnt_r <= c_r + 11'd1;
            st_r <= StIdle;
          end
        end
        StPkRd: st_r <= StEmit;
        StEmit: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_bin_index <= emit_e;
            out_smoothed_db <= win_res;
            out_peak_db <= (emit_e == c_r) ? peak_hold_r : prd_r;
            out_last <= end_r && d_r == '0;
            if (end_r && d_r != '0) begin
              d_r <= d_r - 3'd1;
              st_r <= StPkRd;
            end else begin
              st_r <= StIdle;
              if (end_r) begin
                cnt_r <= '0;
                for (int i = 0; i < ssph_pkg::Taps; i++) taps_r[i] <= '0;
              end else begin
                cnt_r <= c_r + 11'd1;
              end
            end
          end
        end
        default: st_r <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: src/ssph_checker.sv
// port-level checker for the spectrum smoothing block
`default_nettype none
`include "spectrum_smooth_peak_hold_defines.svh"
module ssph_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [10:0] out_bin_index,
  input wire logic        out_last
);
  `SSPH_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped")
  `SSPH_ASSERT(a_idx_hold, clk, rst_n, out_valid && out_stall |=> $stable(out_bin_index), "index moved")
  `SSPH_ASSERT(a_last_hold, clk, rst_n, out_valid && out_stall |=> $stable(out_last), "last moved")
  `SSPH_ASSERT(a_no_take, clk, rst_n, in_valid && !in_stall |=> in_stall, "two transfers back to back")
  `SSPH_NEVER(a_valid_known, clk, rst_n, $isunknown(out_valid), "result valid unknown")
endmodule
bind spectrum_smooth_peak_hold ssph_checker u_ssph_checker (.*);
`default_nettype wire
